// ===== sv/wes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wes_pkg
// Shared types, sizes and helpers of the weekly event scheduler.
// ----------------------------------------------------------------------------
package wes_pkg;

  localparam int NUM_EVENTS = 8;  // 1..8
  localparam int NUM_ZONES  = 8;  // 1..8

  localparam int EvtW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;

  // zone mask bits that can emit
  localparam logic [7:0] ZoneValid = 8'((9'd1 << NUM_ZONES) - 9'd1);

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [2:0] WdayMax = 3'd6;

  typedef struct packed {
    logic        req_type;
    logic [10:0] minute_of_day;
    logic [2:0]  weekday;
    logic [2:0]  entry_index;
    logic        entry_active;
    logic [6:0]  entry_days;
    logic [10:0] entry_minute;
    logic [7:0]  entry_zones;
    logic [7:0]  entry_amount;
  } in_word_t;

  typedef struct packed {
    logic [2:0] zone;
    logic [7:0] amount;
    logic [2:0] event_index;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic        active;
    logic [6:0]  days;
    logic [10:0] minute;
    logic [7:0]  zones;
    logic [7:0]  amount;
    logic        executed;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_en;
    logic tick_en;
    logic pop;
  } wes_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic will_emit;  // tick on the input would produce results
    logic last;       // word on the output is the final one of its tick
  } wes_status_t;

  // index of lowest set bit, 0 when empty
  function automatic logic [2:0] lsb_index8(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (v[k]) r = 3'(k);
    end
    return r;
  endfunction

endpackage

// ===== sv/wes_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wes_in_if / wes_out_if
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
interface wes_in_if;
  logic              valid;
  logic              ready;
  wes_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wes_out_if;
  logic               valid;
  logic               ready;
  wes_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/weekly_event_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weekly_event_scheduler_top
// Weekly event table with tick-driven firing and per-zone result words.
// ----------------------------------------------------------------------------
//  channel | dir | word        | meaning
//  in_i    | in  | in_word_t   | tick (weekday, minute) or one table entry write
//  out_o   | out | out_word_t  | one fired zone: zone, amount, entry, last flag
//
//  A write updates one table entry and gives no result. A tick is matched
//  against all entries at once; if k zones fire, k result words follow, one
//  per cycle while out_o is ready; the tick holds the block until they drain.
//  Reset clears the whole table (inactive, not executed).
//  in_i is not ready while results of a tick are pending; out_o stalls hold
//  the current word.
// ----------------------------------------------------------------------------
module weekly_event_scheduler_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  wes_in_if.sink    in_i,
  wes_out_if.source out_o
);

  wes_pkg::wes_cmd_t    cmd;
  wes_pkg::wes_status_t status;

  // sequencer: owns both handshakes
  wes_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_req_type_i (in_i.data.req_type),
    .in_ready_o    (in_i.ready),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // table and serializer; result word is built from registered state
  wes_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_i.data),
    .status_o   (status),
    .out_word_o (out_o.data)
  );

endmodule

// ===== sv/wes_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wes_ctrl
// Handshake sequencer: idle/accept, then drain the results of one tick.
// ----------------------------------------------------------------------------
module wes_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_req_type_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  wes_pkg::wes_status_t status_i,
  output wes_pkg::wes_cmd_t    cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   in_acc;
  logic   out_acc;

  assign in_acc  = in_valid_i && in_ready_q;
  assign out_acc = out_valid_q && out_ready_i;

  assign cmd_o.wr_en   = in_acc && (in_req_type_i == wes_pkg::REQ_WRITE);
  assign cmd_o.tick_en = in_acc && (in_req_type_i == wes_pkg::REQ_TICK);
  assign cmd_o.pop     = out_acc;

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.tick_en && status_i.will_emit) begin
            state_q     <= ST_EMIT;
            in_ready_q  <= 1'b0;
            out_valid_q <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_acc && status_i.last) begin
            state_q     <= ST_IDLE;
            in_ready_q  <= 1'b1;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== sv/wes_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wes_dp
// Event table, per-entry match logic and the result serializer.
// ----------------------------------------------------------------------------
module wes_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wes_pkg::wes_cmd_t    cmd_i,
  input  wes_pkg::in_word_t    in_word_i,
  output wes_pkg::wes_status_t status_o,
  output wes_pkg::out_word_t   out_word_o
);

  wes_pkg::entry_t               tbl_q [wes_pkg::NUM_EVENTS];
  logic [wes_pkg::NUM_EVENTS-1:0] pend_q;   // entries still to emit
  logic [7:0]                     zdone_q;  // zones of current entry already sent

  logic [wes_pkg::NUM_EVENTS-1:0] fire;
  logic [wes_pkg::NUM_EVENTS-1:0] rearm;
  logic [wes_pkg::NUM_EVENTS-1:0] emit;

  // per-entry match, all entries independent
  always_comb begin
    logic       day_hit;
    logic [7:0] day_vec;
    for (int i = 0; i < wes_pkg::NUM_EVENTS; i++) begin
      day_vec  = {1'b0, tbl_q[i].days};
      day_hit  = tbl_q[i].active && (in_word_i.weekday <= wes_pkg::WdayMax) &&
                 day_vec[in_word_i.weekday];
      fire[i]  = day_hit && !tbl_q[i].executed &&
                 (tbl_q[i].minute == in_word_i.minute_of_day);
      rearm[i] = day_hit && tbl_q[i].executed &&
                 (tbl_q[i].minute < in_word_i.minute_of_day);
      emit[i]  = fire[i] && ((tbl_q[i].zones & wes_pkg::ZoneValid) != 8'd0);
    end
  end

  // current result
  logic [2:0]                     cur8;
  logic [wes_pkg::EvtW-1:0]       cur;
  logic [7:0]                     zrem;
  logic [2:0]                     zone;
  logic                           zone_last;
  logic [wes_pkg::NUM_EVENTS-1:0] others;

  assign cur8      = wes_pkg::lsb_index8(8'(pend_q));
  assign cur       = cur8[wes_pkg::EvtW-1:0];
  assign zrem      = tbl_q[cur].zones & wes_pkg::ZoneValid & ~zdone_q;
  assign zone      = wes_pkg::lsb_index8(zrem);
  assign zone_last = ((zrem & (zrem - 8'd1)) == 8'd0);
  assign others    = pend_q & ~(wes_pkg::NUM_EVENTS'(1) << cur);

  assign status_o.will_emit = (emit != '0);
  assign status_o.last      = zone_last && (others == '0);

  assign out_word_o.zone        = zone;
  assign out_word_o.amount      = tbl_q[cur].amount;
  assign out_word_o.event_index = cur8;
  assign out_word_o.last        = status_o.last;

  logic [wes_pkg::EvtW-1:0] wr_idx;
  logic                     wr_ok;
  assign wr_idx = in_word_i.entry_index[wes_pkg::EvtW-1:0];
  assign wr_ok  = (32'(in_word_i.entry_index) < wes_pkg::NUM_EVENTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wes_pkg::NUM_EVENTS; i++) begin
        tbl_q[i] <= '0;
      end
      pend_q  <= '0;
      zdone_q <= '0;
    end else begin
      if (cmd_i.wr_en && wr_ok) begin
        tbl_q[wr_idx].active   <= in_word_i.entry_active;
        tbl_q[wr_idx].days     <= in_word_i.entry_days;
        tbl_q[wr_idx].minute   <= in_word_i.entry_minute;
        tbl_q[wr_idx].zones    <= in_word_i.entry_zones;
        tbl_q[wr_idx].amount   <= in_word_i.entry_amount;
        tbl_q[wr_idx].executed <= 1'b0;
      end
      if (cmd_i.tick_en) begin
        for (int i = 0; i < wes_pkg::NUM_EVENTS; i++) begin
          if (fire[i]) tbl_q[i].executed <= 1'b1;
          else if (rearm[i]) tbl_q[i].executed <= 1'b0;
        end
        pend_q  <= emit;
        zdone_q <= '0;
      end else if (cmd_i.pop) begin
        if (zone_last) begin
          pend_q[cur] <= 1'b0;
          zdone_q     <= '0;
        end else begin
          zdone_q <= zdone_q | (8'd1 << zone);
        end
      end
    end
  end

endmodule

// ===== sv/wes_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wes_checker
// Port-level checks of the weekly event scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module wes_checker (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      in_req_type_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input logic      out_last_i,
  input logic [14:0] out_data_i
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while results pending");

  a_last_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_last_i) |=> (in_ready_i && !out_valid_i))
    else $error("no return to idle after last word");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_req_type_i) |=> (in_ready_i && !out_valid_i))
    else $error("write produced output");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(out_data_i))
    else $error("output word changed while stalled");

endmodule

bind weekly_event_scheduler_top wes_checker u_wes_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_req_type_i (in_i.data.req_type),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_last_i    (out_o.data.last),
  .out_data_i    (out_o.data)
);

// ===== sim/tb_weekly_event_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weekly_event_scheduler_top
// Self-checking bench for the weekly event scheduler. Requests go in as
// table writes and time ticks. A behavioral copy of the event table predicts
// every zone word that a tick fires, and each word on the output is checked
// in order. Directed tests cover the special cases. Random schedules follow,
// under four idle/stall mixes on the two channels.
// ----------------------------------------------------------------------------
module tb_weekly_event_scheduler_top;

  logic clk_i;
  logic rst_ni;

  wes_in_if  in_bus ();
  wes_out_if out_bus ();

  weekly_event_scheduler_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // percent of cycles the request side sits idle / the result side stalls
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;

  // shadow event table and the zone words still owed by the block
  wes_pkg::entry_t    sched_tbl [wes_pkg::NUM_EVENTS];
  wes_pkg::out_word_t zone_fire_q [$];

  int unsigned mismatch_cnt = 0;
  int unsigned sent_cnt = 0;

  // --------------------------------------------------------------------------
  // Predictor: applies one accepted request word to the shadow table. A tick
  // scans entries in index order; a matching entry either fires (one word per
  // emitting zone, lowest zone first) or, when already executed and its minute
  // is behind now, rearms. The final word of the tick carries last.
  // --------------------------------------------------------------------------
  function automatic void apply_request(input wes_pkg::in_word_t w);
    wes_pkg::out_word_t fired [$];
    wes_pkg::out_word_t r;
    wes_pkg::entry_t    e;
    if (w.req_type == wes_pkg::REQ_WRITE) begin
      if (int'(w.entry_index) < wes_pkg::NUM_EVENTS) begin
        e.active   = w.entry_active;
        e.days     = w.entry_days;
        e.minute   = w.entry_minute;
        e.zones    = w.entry_zones;
        e.amount   = w.entry_amount;
        e.executed = 1'b0;
        sched_tbl[w.entry_index] = e;
      end
    end else begin
      for (int i = 0; i < wes_pkg::NUM_EVENTS; i++) begin
        e = sched_tbl[i];
        // weekday seven has no day bit: nothing matches
        if (e.active && w.weekday <= wes_pkg::WdayMax && e.days[w.weekday]) begin
          if (!e.executed && e.minute == w.minute_of_day) begin
            sched_tbl[i].executed = 1'b1;
            for (int z = 0; z < wes_pkg::NUM_ZONES; z++) begin
              if (e.zones[z]) begin
                r.zone        = 3'(z);
                r.amount      = e.amount;
                r.event_index = 3'(i);
                r.last        = 1'b0;
                fired.push_back(r);
              end
            end
          end else if (e.executed && e.minute < w.minute_of_day) begin
            sched_tbl[i].executed = 1'b0;
          end
        end
      end
      foreach (fired[k]) begin
        r = fired[k];
        r.last = (k == fired.size() - 1);
        zone_fire_q.push_back(r);
      end
    end
  endfunction

  // request word builders; fields the request kind ignores get random filler
  function automatic wes_pkg::in_word_t make_tick(input logic [2:0] wday,
                                                  input logic [10:0] now);
    wes_pkg::in_word_t w;
    w.req_type      = wes_pkg::REQ_TICK;
    w.minute_of_day = now;
    w.weekday       = wday;
    w.entry_index   = 3'($urandom);
    w.entry_active  = 1'($urandom);
    w.entry_days    = 7'($urandom);
    w.entry_minute  = 11'($urandom);
    w.entry_zones   = 8'($urandom);
    w.entry_amount  = 8'($urandom);
    return w;
  endfunction

  function automatic wes_pkg::in_word_t make_write(input logic [2:0] idx, input logic act,
                                                   input logic [6:0] days,
                                                   input logic [10:0] mnt,
                                                   input logic [7:0] zones,
                                                   input logic [7:0] amt);
    wes_pkg::in_word_t w;
    w.req_type      = wes_pkg::REQ_WRITE;
    w.minute_of_day = 11'($urandom);
    w.weekday       = 3'($urandom);
    w.entry_index   = idx;
    w.entry_active  = act;
    w.entry_days    = days;
    w.entry_minute  = mnt;
    w.entry_zones   = zones;
    w.entry_amount  = amt;
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. Called at a falling edge; may idle first, then holds valid
  // until the word is taken, updates the predictor at the accepting edge and
  // returns at the next falling edge. valid stays high across back-to-back
  // words, so it is never lowered and raised in one step.
  // --------------------------------------------------------------------------
  task automatic send_request(input wes_pkg::in_word_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= w;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    apply_request(w);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  // result side backpressure, changed on the falling edge
  always @(negedge clk_i) begin
    out_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted word against the oldest expected one.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : chk_proc
    wes_pkg::out_word_t exp_w;
    wes_pkg::out_word_t act_w;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      act_w = out_bus.data;
      if (zone_fire_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected zone word, expected none actual %h", $realtime, act_w);
      end else begin
        exp_w = zone_fire_q.pop_front();
        if (act_w.zone !== exp_w.zone) begin
          mismatch_cnt++;
          $display("%0t: zone expected %0d actual %0d", $realtime, exp_w.zone, act_w.zone);
        end
        if (act_w.amount !== exp_w.amount) begin
          mismatch_cnt++;
          $display("%0t: amount expected %0d actual %0d", $realtime,
                   exp_w.amount, act_w.amount);
        end
        if (act_w.event_index !== exp_w.event_index) begin
          mismatch_cnt++;
          $display("%0t: event_index expected %0d actual %0d", $realtime,
                   exp_w.event_index, act_w.event_index);
        end
        if (act_w.last !== exp_w.last) begin
          mismatch_cnt++;
          $display("%0t: last expected %0b actual %0b", $realtime, exp_w.last, act_w.last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // all-days / all-zones entry at minute 0, weekday-6-only entry at 1439
  task automatic test_field_extremes();
    send_request(make_write(3'd0, 1'b1, 7'h7F, 11'd0, 8'hFF, 8'hFF));
    send_request(make_write(3'd7, 1'b1, 7'h40, 11'd1439, 8'h81, 8'h00));
    send_request(make_tick(3'd0, 11'd0));
    send_request(make_tick(3'd6, 11'd1439));
  endtask

  // executed entry stays quiet at its minute, rearms once now passes it
  task automatic test_refire_and_rearm();
    send_request(make_tick(3'd0, 11'd0));
    send_request(make_tick(3'd0, 11'd0));
    send_request(make_tick(3'd0, 11'd1));
    send_request(make_tick(3'd0, 11'd0));
  endtask

  // weekday seven matches no entry, so no fire and no rearm
  task automatic test_weekday_seven();
    send_request(make_tick(3'd7, 11'd0));
    send_request(make_tick(3'd7, 11'd1439));
  endtask

  // minutes past 1439 still compare at full width
  task automatic test_minute_overflow();
    send_request(make_write(3'd3, 1'b1, 7'h7F, 11'd2047, 8'h5A, 8'hA5));
    send_request(make_tick(3'd3, 11'd2047));
  endtask

  // empty zone mask fires silently; inactive entry never matches
  task automatic test_empty_zone_mask();
    send_request(make_write(3'd2, 1'b1, 7'h7F, 11'd100, 8'h00, 8'h33));
    send_request(make_tick(3'd2, 11'd100));
    send_request(make_write(3'd4, 1'b0, 7'h7F, 11'd100, 8'hFF, 8'h44));
    send_request(make_tick(3'd2, 11'd100));
  endtask

  // three entries firing on one tick: index order, then zone order, one last
  task automatic test_multi_entry_tick();
    send_request(make_write(3'd1, 1'b1, 7'h08, 11'd500, 8'h03, 8'h01));
    send_request(make_write(3'd5, 1'b1, 7'h08, 11'd500, 8'h80, 8'h02));
    send_request(make_write(3'd6, 1'b1, 7'h7F, 11'd500, 8'h7F, 8'h03));
    send_request(make_tick(3'd3, 11'd500));
  endtask

  // --------------------------------------------------------------------------
  // Random traffic. A session loads a few entries around a base minute and
  // walks ticks across that window, mostly on a matching weekday, with repeats
  // and jumps back so that entries fire, stay quiet and rearm. About one pick
  // in seven is a single fully random request instead of a session.
  // --------------------------------------------------------------------------
  task automatic run_session();
    int unsigned base;
    logic [2:0]  wd;
    logic [10:0] now;
    logic [6:0]  days;
    logic [7:0]  zones;
    int unsigned sel;
    base = ($urandom_range(7) == 0) ? 1435 : $urandom_range(2040);
    wd   = 3'($urandom_range(6));
    repeat ($urandom_range(4, 1)) begin
      days = 7'($urandom);
      if ($urandom_range(3) != 0) days[wd] = 1'b1;
      sel = $urandom_range(5);
      zones = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
      send_request(make_write(3'($urandom), $urandom_range(9) != 0, days,
                              11'(base + $urandom_range(4)), zones, 8'($urandom)));
    end
    now = 11'(base);
    repeat (8) begin
      send_request(make_tick(($urandom_range(6) != 0) ? wd : 3'($urandom), now));
      sel = $urandom_range(9);
      if (sel == 0) now = 11'(base);
      else if (sel != 1) now = now + 11'd1;
    end
  endtask

  task automatic test_random_schedule(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = sent_cnt + n_items;
    while (sent_cnt < stop_at) begin
      if ($urandom_range(6) == 0) begin
        if ($urandom_range(1) == 0) begin
          send_request(make_tick(3'($urandom), 11'($urandom)));
        end else begin
          send_request(make_write(3'($urandom), 1'($urandom), 7'($urandom),
                                  11'($urandom), 8'($urandom), 8'($urandom)));
        end
      end else begin
        run_session();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned wait_cnt;
    foreach (sched_tbl[i]) sched_tbl[i] = '0;
    rst_ni        = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    out_bus.ready = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_field_extremes();
    test_refire_and_rearm();
    test_weekday_seven();
    test_minute_overflow();
    test_empty_zone_mask();
    test_multi_entry_tick();

    // no idling, sender idle, receiver stalling, both
    src_idle_pct = 0;  snk_stall_pct = 0;
    test_random_schedule(105);
    src_idle_pct = 63; snk_stall_pct = 0;
    test_random_schedule(105);
    src_idle_pct = 0;  snk_stall_pct = 63;
    test_random_schedule(105);
    src_idle_pct = 26; snk_stall_pct = 26;
    test_random_schedule(105);

    in_bus.valid <= 1'b0;
    wait_cnt = 0;
    while (zone_fire_q.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (20) @(posedge clk_i);
    if (zone_fire_q.size() != 0)
      $display("%0t: %0d zone words never arrived", $realtime, zone_fire_q.size());
    if (mismatch_cnt == 0 && zone_fire_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/wes_pkg.sv
sv/wes_if.sv
sv/wes_ctrl.sv
sv/wes_dp.sv
sv/weekly_event_scheduler_top.sv
sv/wes_checker.sv
sim/tb_weekly_event_scheduler_top.sv
